// File: rtl/luc_pkg.sv
package luc_pkg;

  // Table and slot geometry.
  localparam int NUMBERS = 128;
  localparam int SLOTS   = 64;

  // Field widths fixed by the interface.
  localparam int NUM_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 7;
  localparam int BUSY_W   = 64;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  // Message type decoding.
  localparam logic [BYTE_W-1:0] TYPE_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] TYPE_NOTE = 8'h90;
  localparam logic [BYTE_W-1:0] TYPE_CC   = 8'hB0;

  // Derived widths.
  localparam int ENTRIES  = 2 * NUMBERS;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int ENT_CW   = $clog2(ENTRIES + 1);
  localparam int SLOT_IW  = $clog2(SLOTS);
  localparam int SLOT_CW  = $clog2(SLOTS + 1);

  // Busy slots are counted a group at a time.
  localparam int CNT_GRP  = (SLOTS < 8) ? SLOTS : 8;
  localparam int CNT_NGRP = SLOTS / CNT_GRP;
  localparam int GRP_W    = (CNT_NGRP > 1) ? $clog2(CNT_NGRP) : 1;

  // Queue depths between and after the two halves.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] SAFE_SLOTS_RST      = 7'd48;
  localparam logic [CFG_W-1:0] NORMAL_BUDGET_RST   = 7'd8;
  localparam logic [CFG_W-1:0] OVERTAKE_BUDGET_RST = 7'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFE_SLOTS      = 2'd0,
    CFG_NORMAL_BUDGET   = 2'd1,
    CFG_OVERTAKE_BUDGET = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_BUDGET,
    ST_SCAN,
    ST_CAPT,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  cable;
    logic [BYTE_W-1:0]  status;
    logic [COLOR_W-1:0] color;
  } payload_t;

  typedef struct packed {
    logic               is_flush;
    logic [IDX_W-1:0]   idx;
    payload_t           payload;
    logic               overtake;
    logic [SLOTS-1:0]   busy;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_IW-1:0] slot;
    logic [BYTE_W-1:0]  cable;
    logic [BYTE_W-1:0]  status;
    logic [NUM_W-1:0]   number;
    logic [COLOR_W-1:0] color;
    logic               last;
  } res_t;

endpackage

// File: rtl/luc_front.sv
module luc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [luc_pkg::BYTE_W-1:0]  cable_code_i,
  input  logic [luc_pkg::BYTE_W-1:0]  status_byte_i,
  input  logic [luc_pkg::NUM_W-1:0]   number_i,
  input  logic [luc_pkg::COLOR_W-1:0] color_i,
  input  logic                        overtake_i,
  input  logic [luc_pkg::BUSY_W-1:0]  slot_busy_i,
  input  logic                        cmd_pop_i,
  output logic                        cmd_vld_o,
  output luc_pkg::cmd_t               cmd_o
);

  localparam int QD     = luc_pkg::CMDQ_DEPTH;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);

  logic [luc_pkg::BYTE_W-1:0] msg_type;
  logic                       is_note;
  logic                       is_cc;
  logic                       num_ok;
  logic                       keep;
  logic                       enq;
  logic                       deq;
  luc_pkg::cmd_t              cmd_new;

  luc_pkg::cmd_t              ent_q [QD];
  logic [QPTR_W-1:0]          wr_q, wr_d;
  logic [QPTR_W-1:0]          rd_q, rd_d;
  logic [QCNT_W-1:0]          cnt_q, cnt_d;

  // Classify the request: queue requests of other types or out-of-range numbers
  // are accepted but never reach the back end.
  always_comb begin
    msg_type = status_byte_i & luc_pkg::TYPE_MASK;
    is_note  = (msg_type == luc_pkg::TYPE_NOTE);
    is_cc    = (msg_type == luc_pkg::TYPE_CC);
    num_ok   = ({1'b0, number_i} < 8'(luc_pkg::NUMBERS));
    keep     = action_i || (num_ok && (is_note || is_cc));

    cmd_new.is_flush = action_i;
    cmd_new.idx      = luc_pkg::IDX_W'(number_i) +
                       (is_cc ? luc_pkg::IDX_W'(luc_pkg::NUMBERS) : '0);
    cmd_new.payload.cable  = cable_code_i;
    cmd_new.payload.status = status_byte_i;
    cmd_new.payload.color  = color_i;
    cmd_new.overtake = overtake_i;
    cmd_new.busy     = slot_busy_i[luc_pkg::SLOTS-1:0];
  end

  assign full      = (cnt_q == QCNT_W'(QD));
  assign enq       = push && !full && keep;
  assign cmd_vld_o = (cnt_q != '0);
  assign deq       = cmd_pop_i && cmd_vld_o;
  assign cmd_o     = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (enq) begin
      wr_d = (wr_q == QPTR_W'(QD - 1)) ? '0 : wr_q + 1'b1;
    end
    if (deq) begin
      rd_d = (rd_q == QPTR_W'(QD - 1)) ? '0 : rd_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enq && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/luc_res_queue.sv
module luc_res_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  input  luc_pkg::res_t res_i,
  output logic          res_full_o,
  input  logic          pop,
  output logic          empty,
  output luc_pkg::res_t res_o
);

  localparam int QD     = luc_pkg::RESQ_DEPTH;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);

  luc_pkg::res_t     ent_q [QD];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              enq;
  logic              deq;

  assign res_full_o = (cnt_q == QCNT_W'(QD));
  assign empty      = (cnt_q == '0);
  assign enq        = res_push_i && !res_full_o;
  assign deq        = pop && !empty;
  assign res_o      = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (enq) begin
      wr_d = (wr_q == QPTR_W'(QD - 1)) ? '0 : wr_q + 1'b1;
    end
    if (deq) begin
      rd_d = (rd_q == QPTR_W'(QD - 1)) ? '0 : rd_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enq && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_q] <= res_i;
    end
  end

endmodule

// File: rtl/luc_back.sv
module luc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [luc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [luc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          cmd_vld_i,
  input  luc_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          res_push_o,
  output luc_pkg::res_t                 res_o,
  input  logic                          res_full_i
);

  localparam int IDX_W   = luc_pkg::IDX_W;
  localparam int ENT_CW  = luc_pkg::ENT_CW;
  localparam int SLOT_CW = luc_pkg::SLOT_CW;
  localparam int SLOT_IW = luc_pkg::SLOT_IW;
  localparam int CFG_W   = luc_pkg::CFG_W;
  localparam int GRP_W   = luc_pkg::GRP_W;
  localparam int CNT_GRP = luc_pkg::CNT_GRP;

  luc_pkg::back_state_e state_q, state_d;

  logic [CFG_W-1:0]         safe_slots_q;
  logic [CFG_W-1:0]         normal_budget_q;
  logic [CFG_W-1:0]         overtake_budget_q;

  logic [luc_pkg::SLOTS-1:0] busy_q, busy_d;
  logic                     ovt_q, ovt_d;
  logic [SLOT_CW-1:0]       used_q, used_d;
  logic [GRP_W-1:0]         grp_q, grp_d;
  logic [ENT_CW-1:0]        ent_q, ent_d;
  logic [SLOT_CW-1:0]       slot_q, slot_d;
  logic [CFG_W-1:0]         sent_q, sent_d;
  logic [CFG_W-1:0]         budget_q, budget_d;
  logic [SLOT_IW-1:0]       cur_slot_q, cur_slot_d;
  logic [luc_pkg::NUM_W-1:0] cur_num_q, cur_num_d;

  luc_pkg::res_t            hold_q, hold_d;
  logic                     hold_vld_q, hold_vld_d;

  logic [luc_pkg::ENTRIES-1:0] mark_q;
  luc_pkg::payload_t        mem [luc_pkg::ENTRIES];
  luc_pkg::payload_t        rd_q;

  logic                     mem_we;
  logic                     rd_en;
  logic [IDX_W-1:0]         ent_idx;
  logic [SLOT_IW-1:0]       slot_idx;
  logic [SLOT_CW-1:0]       grp_cnt;
  logic [CNT_GRP-1:0]       grp_bits;
  logic [CFG_W:0]           limit;
  logic [CFG_W:0]           room;
  logic [CFG_W-1:0]         mode_budget;

  assign ent_idx  = ent_q[IDX_W-1:0];
  assign slot_idx = slot_q[SLOT_IW-1:0];

  // Busy bits of the current group.
  always_comb begin
    grp_bits = busy_q[grp_q * CNT_GRP +: CNT_GRP];
    grp_cnt  = '0;
    for (int k = 0; k < CNT_GRP; k++) begin
      grp_cnt = grp_cnt + SLOT_CW'(grp_bits[k]);
    end
  end

  always_comb begin
    limit       = ovt_q ? (CFG_W + 1)'(luc_pkg::SLOTS) : {1'b0, safe_slots_q};
    room        = limit - (CFG_W + 1)'(used_q);
    mode_budget = ovt_q ? overtake_budget_q : normal_budget_q;
  end

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    ovt_d      = ovt_q;
    used_d     = used_q;
    grp_d      = grp_q;
    ent_d      = ent_q;
    slot_d     = slot_q;
    sent_d     = sent_q;
    budget_d   = budget_q;
    cur_slot_d = cur_slot_q;
    cur_num_d  = cur_num_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    res_push_o = 1'b0;
    res_o      = hold_q;

    unique case (state_q)
      luc_pkg::ST_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_flush) begin
            mem_we = 1'b1;
          end else begin
            busy_d  = cmd_i.busy;
            ovt_d   = cmd_i.overtake;
            used_d  = '0;
            grp_d   = '0;
            state_d = luc_pkg::ST_COUNT;
          end
        end
      end

      luc_pkg::ST_COUNT: begin
        used_d = used_q + grp_cnt;
        if (grp_q == GRP_W'(luc_pkg::CNT_NGRP - 1)) begin
          state_d = luc_pkg::ST_BUDGET;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end

      luc_pkg::ST_BUDGET: begin
        ent_d  = '0;
        slot_d = '0;
        sent_d = '0;
        // The room is negative or zero when the limit does not exceed the count.
        if (limit <= (CFG_W + 1)'(used_q) || mode_budget == '0) begin
          state_d = luc_pkg::ST_IDLE;
        end else begin
          budget_d = ((CFG_W + 1)'(mode_budget) > room) ? room[CFG_W-1:0] : mode_budget;
          state_d  = luc_pkg::ST_SCAN;
        end
      end

      luc_pkg::ST_SCAN: begin
        if (sent_q == budget_q || ent_q == ENT_CW'(luc_pkg::ENTRIES) ||
            slot_q == SLOT_CW'(luc_pkg::SLOTS)) begin
          state_d = luc_pkg::ST_FIN;
        end else if (busy_q[slot_idx]) begin
          slot_d = slot_q + 1'b1;
        end else if (mark_q[ent_idx]) begin
          rd_en      = 1'b1;
          cur_slot_d = slot_idx;
          cur_num_d  = (ent_idx >= IDX_W'(luc_pkg::NUMBERS)) ?
                       luc_pkg::NUM_W'(ent_idx - IDX_W'(luc_pkg::NUMBERS)) :
                       luc_pkg::NUM_W'(ent_idx);
          slot_d     = slot_q + 1'b1;
          sent_d     = sent_q + 1'b1;
          ent_d      = ent_q + 1'b1;
          state_d    = luc_pkg::ST_CAPT;
        end else begin
          ent_d = ent_q + 1'b1;
        end
      end

      luc_pkg::ST_CAPT: begin
        // The previous message is only known not to be the last once the
        // next one has been found, so it waits in the hold register.
        if (!hold_vld_q || !res_full_i) begin
          res_push_o    = hold_vld_q;
          res_o.last    = 1'b0;
          hold_d.slot   = cur_slot_q;
          hold_d.cable  = rd_q.cable;
          hold_d.status = rd_q.status;
          hold_d.number = cur_num_q;
          hold_d.color  = rd_q.color;
          hold_d.last   = 1'b0;
          hold_vld_d    = 1'b1;
          state_d       = luc_pkg::ST_SCAN;
        end
      end

      luc_pkg::ST_FIN: begin
        if (!hold_vld_q) begin
          state_d = luc_pkg::ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = luc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = luc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= luc_pkg::ST_IDLE;
      hold_vld_q <= 1'b0;
      mark_q     <= '0;
      ovt_q      <= 1'b0;
      used_q     <= '0;
      grp_q      <= '0;
      ent_q      <= '0;
      slot_q     <= '0;
      sent_q     <= '0;
      budget_q   <= '0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      ovt_q      <= ovt_d;
      used_q     <= used_d;
      grp_q      <= grp_d;
      ent_q      <= ent_d;
      slot_q     <= slot_d;
      sent_q     <= sent_d;
      budget_q   <= budget_d;
      if (mem_we) begin
        mark_q[cmd_i.idx] <= 1'b1;
      end
      if (rd_en) begin
        mark_q[ent_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_slots_q      <= luc_pkg::SAFE_SLOTS_RST;
      normal_budget_q   <= luc_pkg::NORMAL_BUDGET_RST;
      overtake_budget_q <= luc_pkg::OVERTAKE_BUDGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        luc_pkg::CFG_SAFE_SLOTS:      safe_slots_q      <= cfg_data_i;
        luc_pkg::CFG_NORMAL_BUDGET:   normal_budget_q   <= cfg_data_i;
        luc_pkg::CFG_OVERTAKE_BUDGET: overtake_budget_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    busy_q     <= busy_d;
    cur_slot_q <= cur_slot_d;
    cur_num_q  <= cur_num_d;
    hold_q     <= hold_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.idx] <= cmd_i.payload;
    end
    if (rd_en) begin
      rd_q <= mem[ent_idx];
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_sent_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == luc_pkg::ST_SCAN) |-> (sent_q <= budget_q))
    else $error("more messages sent than the budget allows");

  a_capt_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == luc_pkg::ST_CAPT && $past(state_q) != luc_pkg::ST_CAPT) |->
    $past(rd_en))
    else $error("capture without a payload read");

  a_last_empties_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last) |=> !hold_vld_q)
    else $error("hold register still valid after the last message");

endmodule

// File: rtl/led_update_coalescing_flush.sv
// LED update coalescing queue with a budgeted flush.
// Input requests arrive on a queue-style port: a request is taken at a clock
// edge where push is high and full is low. A queue request (action 0) with a
// note or control status stores its payload against its type and number, replacing
// any older pending one; other statuses are accepted and dropped. A flush
// request (action 1) carries the slot occupancy mask and the overtake flag.
// Results leave through a queue-style port: while empty is low the oldest
// result is on the outputs, and it is taken where pop is high.
// A queue request is written into the tables at the first clock edge after
// acceptance at which the back end is idle and the request heads the queue.
// A flush counts the busy slots a group at a time, works out its budget,
// then scans the 256 table entries, skipping busy slots, and reads the
// payload of each message sent; it ends early when there is no room or
// no budget, and the scan stalls while results wait.
// The last message of a flush leaves once the scan has ended. The scan of the
// shared payload memory limits throughput to one flush at a time.
// A two-entry request queue lets the front accept while a flush is running;
// when the receiver stops popping, the scan stalls and requests back up.
// Reset clears all pending marks and the request and result queues, and
// loads the registers with their defaults; no clearing pass is needed.
module led_update_coalescing_flush (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [luc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [luc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          action_i,
  input  logic [luc_pkg::BYTE_W-1:0]    cable_code_i,
  input  logic [luc_pkg::BYTE_W-1:0]    status_byte_i,
  input  logic [luc_pkg::NUM_W-1:0]     number_i,
  input  logic [luc_pkg::COLOR_W-1:0]   color_i,
  input  logic                          overtake_i,
  input  logic [luc_pkg::BUSY_W-1:0]    slot_busy_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [luc_pkg::SLOT_IW-1:0]   slot_o,
  output logic [luc_pkg::BYTE_W-1:0]    out_cable_code_o,
  output logic [luc_pkg::BYTE_W-1:0]    out_status_o,
  output logic [luc_pkg::NUM_W-1:0]     out_number_o,
  output logic [luc_pkg::COLOR_W-1:0]   out_color_o,
  output logic                          last_o
);

  logic          cmd_vld;
  logic          cmd_pop;
  luc_pkg::cmd_t cmd;
  logic          res_push;
  logic          res_full;
  luc_pkg::res_t res_in;
  luc_pkg::res_t res_out;

  luc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .cable_code_i  (cable_code_i),
    .status_byte_i (status_byte_i),
    .number_i      (number_i),
    .color_i       (color_i),
    .overtake_i    (overtake_i),
    .slot_busy_i   (slot_busy_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd)
  );

  luc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_vld_i  (cmd_vld),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  luc_res_queue u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_out)
  );

  assign slot_o           = res_out.slot;
  assign out_cable_code_o = res_out.cable;
  assign out_status_o     = res_out.status;
  assign out_number_o     = res_out.number;
  assign out_color_o      = res_out.color;
  assign last_o           = res_out.last;

endmodule
